@@ sv/rtc3w_pkg.sv @@
// Shared types and constants of the three-wire serial master.
package rtc3w_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned BitIdxW = 3;

  localparam logic [HalfW-1:0]   HalfPeriodReset = 16'd4;
  localparam logic [BitIdxW-1:0] LastBit         = 3'd7;

  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhPre  = 3'd1,
    PhTxHi = 3'd2,
    PhTxLo = 3'd3,
    PhGap  = 3'd4,
    PhRxHi = 3'd5,
    PhRxLo = 3'd6
  } phase_e;

  // One tick as presented to the sequencer.
  typedef struct packed {
    logic             start_req;
    logic             op;
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] write_data;
    logic             data_pin;
  } tick_t;

  // Line levels and status after one tick.
  typedef struct packed {
    logic             chip_enable;
    logic             serial_clock;
    logic             data_out;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_data;
  } line_t;

endpackage

@@ sv/rtc3w_req_if.sv @@
// Request channel carrying one tick of the serial master.
interface rtc3w_req_if;
  logic                    valid;
  logic                    ready;
  logic                    start_req;
  logic                    op;
  logic [rtc3w_pkg::ByteW-1:0] address;
  logic [rtc3w_pkg::ByteW-1:0] write_data;
  logic                    data_pin;

  modport source (output valid, start_req, op, address, write_data, data_pin, input ready);
  modport sink   (input valid, start_req, op, address, write_data, data_pin, output ready);
endinterface

@@ sv/rtc3w_res_if.sv @@
// Result channel carrying the line levels after each tick.
interface rtc3w_res_if;
  logic                    valid;
  logic                    ready;
  logic                    chip_enable;
  logic                    serial_clock;
  logic                    data_out;
  logic                    busy_res;
  logic                    done_res;
  logic [rtc3w_pkg::ByteW-1:0] read_data;

  modport source (output valid, chip_enable, serial_clock, data_out, busy_res, done_res,
                  read_data, input ready);
  modport sink   (input valid, chip_enable, serial_clock, data_out, busy_res, done_res,
                  read_data, output ready);
endinterface

@@ sv/rtc3w_seq.sv @@
// Bit sequencer: phase state machine, delay counter, shift registers and line levels.
module rtc3w_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  rtc3w_pkg::tick_t               tick_i,
  input  logic [rtc3w_pkg::HalfW-1:0]    half_period_i,
  output rtc3w_pkg::line_t               line_o
);

  rtc3w_pkg::phase_e                  phase_q, phase_d;
  logic [rtc3w_pkg::HalfW-1:0]        delay_q, delay_d;
  logic [rtc3w_pkg::BitIdxW-1:0]      bit_q, bit_d;
  logic                               byte_q, byte_d;
  logic [rtc3w_pkg::ByteW-1:0]        tx_q, tx_d;
  logic [rtc3w_pkg::ByteW-1:0]        pend_q, pend_d;
  logic [rtc3w_pkg::ByteW-1:0]        rx_q, rx_d;
  logic [rtc3w_pkg::ByteW-1:0]        last_q, last_d;
  logic                               is_read_q, is_read_d;
  logic                               ce_q, ce_d;
  logic                               sclk_q, sclk_d;
  logic                               dat_q, dat_d;
  logic                               done;
  logic                               timeout;
  logic [rtc3w_pkg::HalfW-1:0]        period_m1;
  logic [rtc3w_pkg::BitIdxW-1:0]      bit_inc;

  assign timeout   = (delay_q == '0);
  // A zero half period behaves as one tick.
  assign period_m1 = (half_period_i == '0) ? '0 : half_period_i - 1'b1;
  assign bit_inc   = bit_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      rtc3w_pkg::PhIdle: if (tick_i.start_req) phase_d = rtc3w_pkg::PhPre;
      rtc3w_pkg::PhPre:  if (timeout) phase_d = rtc3w_pkg::PhTxHi;
      rtc3w_pkg::PhTxHi: if (timeout) phase_d = rtc3w_pkg::PhTxLo;
      rtc3w_pkg::PhTxLo: begin
        if (timeout) begin
          phase_d = (bit_q != rtc3w_pkg::LastBit) ? rtc3w_pkg::PhTxHi : rtc3w_pkg::PhGap;
        end
      end
      rtc3w_pkg::PhGap: begin
        if (timeout) begin
          if (!byte_q) begin
            phase_d = is_read_q ? rtc3w_pkg::PhRxHi : rtc3w_pkg::PhPre;
          end else begin
            phase_d = rtc3w_pkg::PhIdle;
          end
        end
      end
      rtc3w_pkg::PhRxHi: if (timeout) phase_d = rtc3w_pkg::PhRxLo;
      rtc3w_pkg::PhRxLo: begin
        if (timeout) begin
          phase_d = (bit_q != rtc3w_pkg::LastBit) ? rtc3w_pkg::PhRxHi : rtc3w_pkg::PhIdle;
        end
      end
      default: phase_d = rtc3w_pkg::PhIdle;
    endcase
  end

  always_comb begin
    bit_d     = bit_q;
    byte_d    = byte_q;
    tx_d      = tx_q;
    pend_d    = pend_q;
    rx_d      = rx_q;
    last_d    = last_q;
    is_read_d = is_read_q;
    ce_d      = ce_q;
    sclk_d    = sclk_q;
    dat_d     = dat_q;
    done      = 1'b0;

    if (phase_q != rtc3w_pkg::PhIdle && !timeout) begin
      delay_d = delay_q - 1'b1;
    end else if (phase_d == rtc3w_pkg::PhIdle) begin
      delay_d = '0;
    end else begin
      delay_d = period_m1;
    end

    unique case (phase_q) inside
      rtc3w_pkg::PhIdle: begin
        if (tick_i.start_req) begin
          is_read_d = tick_i.op;
          tx_d      = tick_i.address;
          pend_d    = tick_i.write_data;
          bit_d     = '0;
          byte_d    = 1'b0;
          rx_d      = '0;
          ce_d      = 1'b1;
          sclk_d    = 1'b0;
        end
      end
      rtc3w_pkg::PhPre: begin
        if (timeout) begin
          bit_d  = '0;
          dat_d  = tx_q[0];
          sclk_d = 1'b1;
        end
      end
      rtc3w_pkg::PhTxHi, rtc3w_pkg::PhRxHi: begin
        if (timeout) sclk_d = 1'b0;
      end
      rtc3w_pkg::PhTxLo: begin
        if (timeout) begin
          if (bit_q != rtc3w_pkg::LastBit) begin
            bit_d  = bit_inc;
            dat_d  = tx_q[bit_inc];
            sclk_d = 1'b1;
          end else begin
            dat_d = 1'b1;
          end
        end
      end
      rtc3w_pkg::PhGap: begin
        if (timeout) begin
          if (!byte_q && !is_read_q) begin
            // Second byte of a write; the data line stays released during its lead-in.
            byte_d = 1'b1;
            tx_d   = pend_q;
            bit_d  = '0;
          end else if (!byte_q) begin
            byte_d = 1'b1;
            bit_d  = '0;
            sclk_d = 1'b1;
            rx_d   = {tick_i.data_pin, {(rtc3w_pkg::ByteW-1){1'b0}}};
          end else begin
            ce_d = 1'b0;
            done = 1'b1;
          end
        end
      end
      rtc3w_pkg::PhRxLo: begin
        if (timeout) begin
          if (bit_q != rtc3w_pkg::LastBit) begin
            bit_d  = bit_inc;
            sclk_d = 1'b1;
            rx_d   = {tick_i.data_pin, rx_q[rtc3w_pkg::ByteW-1:1]};
          end else begin
            last_d = rx_q;
            ce_d   = 1'b0;
            dat_d  = 1'b0;
            done   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rtc3w_pkg::PhIdle;
      delay_q   <= '0;
      bit_q     <= '0;
      byte_q    <= 1'b0;
      tx_q      <= '0;
      pend_q    <= '0;
      rx_q      <= '0;
      last_q    <= '0;
      is_read_q <= 1'b0;
      ce_q      <= 1'b0;
      sclk_q    <= 1'b0;
      dat_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      delay_q   <= delay_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      tx_q      <= tx_d;
      pend_q    <= pend_d;
      rx_q      <= rx_d;
      last_q    <= last_d;
      is_read_q <= is_read_d;
      ce_q      <= ce_d;
      sclk_q    <= sclk_d;
      dat_q     <= dat_d;
    end
  end

  always_comb begin
    line_o.chip_enable  = ce_d;
    line_o.serial_clock = sclk_d;
    line_o.data_out     = dat_d;
    line_o.busy_res     = (phase_d != rtc3w_pkg::PhIdle);
    line_o.done_res     = done;
    line_o.read_data    = last_d;
  end

endmodule

@@ sv/three_wire_rtc_serial_master.sv @@
// Top level of the three-wire serial master: config register, sequencer and result register.
//
//   Channel   Direction  Handshake      Contents
//   req_i     in         valid/ready    one tick: start_req, op, address, write_data, data_pin
//   res_o     out        valid/ready    line levels, busy, done and last read byte after the tick
//   cfg       in         cfg_we_i       half_period, ticks per clock phase and gap
//
// The result of each request appears in the result register on the next cycle; a new
// request is taken every cycle while the result register is empty or is being drained.
// When the result side stalls, the request side stalls with it.
// Reset sets the lines low, the sequencer idle, the last read byte to zero and half_period to 4.
module three_wire_rtc_serial_master (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rtc3w_pkg::HalfW-1:0] cfg_wdata_i,
  rtc3w_req_if.sink                   req_i,
  rtc3w_res_if.source                 res_o
);

  logic [rtc3w_pkg::HalfW-1:0] half_period_q;
  logic                        res_valid_q;
  rtc3w_pkg::line_t            res_q;
  rtc3w_pkg::line_t            line;
  rtc3w_pkg::tick_t            tick;
  logic                        step;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign step        = req_i.valid && req_i.ready;

  assign tick.start_req  = req_i.start_req;
  assign tick.op         = req_i.op;
  assign tick.address    = req_i.address;
  assign tick.write_data = req_i.write_data;
  assign tick.data_pin   = req_i.data_pin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= rtc3w_pkg::HalfPeriodReset;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  rtc3w_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .tick_i        (tick),
    .half_period_i (half_period_q),
    .line_o        (line)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= line;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.chip_enable  = res_q.chip_enable;
  assign res_o.serial_clock = res_q.serial_clock;
  assign res_o.data_out     = res_q.data_out;
  assign res_o.busy_res     = res_q.busy_res;
  assign res_o.done_res     = res_q.done_res;
  assign res_o.read_data    = res_q.read_data;

endmodule
